FILE: rtl/core/sorted_set_store_defines.svh
// assertion macros shared by the sorted set store checker
// no dependencies; included by files that assert
`ifndef SORTED_SET_STORE_DEFINES_SVH
`define SORTED_SET_STORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SSS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted_set_store check failed");

// next-cycle implication, disabled during reset
`define SSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted_set_store check failed");

`endif

FILE: rtl/core/sss_pkg.sv
// shared constants, request codes and control structs for the sorted set store
// no dependencies
package sss_pkg;

  localparam int CAPACITY = 16;
  localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW       = $clog2(CAPACITY + 1);

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  typedef struct packed {
    logic start;
    logic run;
    logic finish;
  } sss_cmd_t;

  typedef struct packed {
    logic scan_end;
  } sss_stat_t;

endpackage

FILE: rtl/core/sss_ctrl.sv
// sequencer for the sorted set store: input handshake, scan control, result register valid
// depends on sss_pkg
module sss_ctrl import sss_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  output logic      m_tvalid,
  input  logic      m_tready,
  input  sss_stat_t stat,
  output sss_cmd_t  cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state;
  logic state_next;
  logic m_tvalid_next;

  always_comb begin
    s_tready   = (state == ST_IDLE);
    cmd.start  = s_tvalid && (state == ST_IDLE);
    cmd.run    = (state == ST_RUN);
    // result slot must be free before the store commits
    cmd.finish = (state == ST_RUN) && stat.scan_end && (!m_tvalid || m_tready);

    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.start) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (cmd.finish) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase

    m_tvalid_next = m_tvalid;
    if (cmd.finish) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

endmodule

FILE: rtl/core/sss_datapath.sv
// store, scan pipeline and result register of the sorted set store
// depends on sss_pkg; driven by sss_ctrl through sss_cmd_t
module sss_datapath import sss_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  sss_cmd_t           cmd,
  output sss_stat_t          stat,
  input  logic [1:0]         in_type,
  input  logic signed [31:0] in_value,
  output logic               was_present,
  output logic [4:0]         element_count,
  output logic signed [31:0] smallest_element,
  output logic               is_empty,
  output logic               error_code
);

  localparam logic [1:0] MODE_SEARCH = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  logic [31:0]        mem [CAPACITY];
  logic [31:0]        rd_data;

  logic [1:0]         req;
  logic signed [31:0] val;
  logic [CW-1:0]      cnt;
  logic [CW-1:0]      cnt_next;
  logic signed [31:0] least;
  logic signed [31:0] least_next;
  logic [CW-1:0]      ptr;
  logic               chk_valid;
  logic [AW-1:0]      chk_idx;
  logic [1:0]         mode;
  logic [1:0]         mode_next;
  logic signed [31:0] carry;
  logic signed [31:0] carry_next;
  logic               found;
  logic               found_next;
  logic               halt;
  logic               halt_next;

  logic               full;
  logic               do_add;
  logic               do_rem;
  logic               rd_en;
  logic               proc;
  logic signed [31:0] e;
  logic               we;
  logic [AW-1:0]      wa;
  logic [31:0]        wd;

  always_comb begin
    full   = (cnt == CW'(CAPACITY));
    do_add = (req == REQ_ADD);
    do_rem = (req == REQ_REMOVE);
    rd_en  = cmd.run && !halt && (ptr < cnt);
    proc   = cmd.run && chk_valid && !halt;
    e      = $signed(rd_data);
    stat.scan_end = halt || ((ptr >= cnt) && !chk_valid);

    we         = 1'b0;
    wa         = chk_idx;
    wd         = carry;
    mode_next  = mode;
    carry_next = carry;
    found_next = found;
    halt_next  = halt;
    cnt_next   = cnt;

    if (proc) begin
      case (mode)
        MODE_SEARCH: begin
          if (e == val) begin
            found_next = 1'b1;
            if (do_rem) mode_next = MODE_REMOVE;
            else        halt_next = 1'b1;
          end else if (e > val) begin
            // first larger entry: value is absent; an add to a non-full store starts insertion here
            if (do_add && !full) begin
              we         = 1'b1;
              wd         = val;
              carry_next = e;
              mode_next  = MODE_INSERT;
            end else begin
              halt_next = 1'b1;
            end
          end
        end
        MODE_INSERT: begin
          we         = 1'b1;
          wd         = carry;
          carry_next = e;
        end
        MODE_REMOVE: begin
          // close the gap one entry down
          we = 1'b1;
          wa = chk_idx - AW'(1);
          wd = e;
        end
        default: ;
      endcase
    end

    if (cmd.finish) begin
      if (mode == MODE_INSERT) begin
        we       = 1'b1;
        wa       = cnt[AW-1:0];
        wd       = carry;
        cnt_next = cnt + CW'(1);
      end else if (mode == MODE_SEARCH && !found && do_add && !full) begin
        // value above every entry, append at the end
        we       = 1'b1;
        wa       = cnt[AW-1:0];
        wd       = val;
        cnt_next = cnt + CW'(1);
      end else if (mode == MODE_REMOVE) begin
        cnt_next = cnt - CW'(1);
      end
    end

    // head entry mirrored in a register
    least_next = (we && wa == '0) ? $signed(wd) : least;
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (rd_en) rd_data <= mem[ptr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      chk_valid <= 1'b0;
    end else if (cmd.start) begin
      req       <= in_type;
      val       <= in_value;
      ptr       <= '0;
      chk_valid <= 1'b0;
      mode      <= MODE_SEARCH;
      found     <= 1'b0;
      halt      <= 1'b0;
    end else begin
      ptr       <= ptr + CW'(rd_en);
      chk_valid <= rd_en;
      chk_idx   <= ptr[AW-1:0];
      mode      <= mode_next;
      carry     <= carry_next;
      found     <= found_next;
      halt      <= halt_next;
      cnt       <= cnt_next;
      least     <= least_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      was_present      <= found;
      element_count    <= 5'(cnt_next);
      smallest_element <= (cnt_next == '0) ? 32'sd0 : least_next;
      is_empty         <= (cnt_next == '0);
      error_code       <= do_add && full && !found;
    end
  end

endmodule

FILE: rtl/core/sorted_set_store.sv
// channel   | dir | beat contents
// s_*       | in  | tuser: req_type; tdata: elem_value
// m_*       | out | tdata: was_present, element_count, smallest_element, is_empty, error_code
//
// a request is accepted when idle; the store is walked one entry per cycle with a registered read,
// and the scan stops at a match or a larger entry unless a remove or an add to a non-full store
// must shift entries; the result is loaded when the scan ends and the result slot is free
// a new request is accepted once the result is loaded, even if not yet taken
// rst is synchronous and empties the set; the store needs no clearing pass
// a stalled result holds and delays only the commit of the following request
// top level of the sorted set store; depends on sss_pkg, sss_ctrl and sss_datapath
module sorted_set_store import sss_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] elem_value
  input  logic [1:0]  s_tuser,   // [1:0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // [0] was_present, [5:1] element_count,
                                 // [37:6] smallest_element, [38] is_empty, [39] error_code
);

  sss_cmd_t           cmd;
  sss_stat_t          stat;
  logic               was_present;
  logic [4:0]         element_count;
  logic signed [31:0] smallest_element;
  logic               is_empty;
  logic               error_code;

  sss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sss_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .in_type          (s_tuser),
    .in_value         ($signed(s_tdata)),
    .was_present      (was_present),
    .element_count    (element_count),
    .smallest_element (smallest_element),
    .is_empty         (is_empty),
    .error_code       (error_code)
  );

  assign m_tdata = {error_code, is_empty, smallest_element, element_count, was_present};

endmodule

FILE: rtl/core/sss_checker.sv
// port-level checks for the sorted set store, bound to the top level
// depends on sss_pkg and sorted_set_store_defines.svh
`include "sorted_set_store_defines.svh"

module sss_checker import sss_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  logic        out_present;
  logic [4:0]  out_count;
  logic [31:0] out_least;
  logic        out_empty;
  logic        out_error;

  assign out_present = m_tdata[0];
  assign out_count   = m_tdata[5:1];
  assign out_least   = m_tdata[37:6];
  assign out_empty   = m_tdata[38];
  assign out_error   = m_tdata[39];

  // a stalled result beat holds
  `SSS_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // one request at a time: input closes after an accepted beat
  `SSS_ASSERT_NEXT(a_in_busy, clk, rst, s_tvalid && s_tready, !s_tready)

  // empty flag agrees with the count
  `SSS_ASSERT_IMPLY(a_empty_count, clk, rst, m_tvalid, (CAPACITY >= 32) || (out_empty == (out_count == 5'd0)))

  // an empty set reports zero as its least element
  `SSS_ASSERT_IMPLY(a_empty_zero, clk, rst, m_tvalid && out_empty, out_least == 32'd0)

  // a dropped add only for an absent value on a full store
  `SSS_ASSERT_IMPLY(a_err_full, clk, rst, m_tvalid && out_error, !out_present && (out_count == 5'(CAPACITY)))

endmodule

bind sorted_set_store sss_checker u_sss_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
